FILE: src/cds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types and constants of the CAN datagram segmenter.
// ----------------------------------------------------------------------------
package cds_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam int ID_W        = 29;
    localparam int LEN_W       = 4;
    localparam int FRAME_BYTES = 8;
    localparam int PLEN_W      = 15;
    localparam int FILL_W      = 3;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 104;

    localparam logic [7:0]        LEVEL_BASE   = 8'h30;
    localparam logic [7:0]        FIRST_PART   = 8'h01;
    localparam logic [PLEN_W-1:0] HEADER_EXTRA = 15'd3;
    localparam logic [FILL_W-1:0] HEADER_FILL  = 3'd7;
    localparam logic [LEN_W-1:0]  HEADER_LEN   = 4'd7;

    typedef enum logic
    {
        CMD_START = 1'b0,
        CMD_DATA  = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t              command;
        logic [6:0]        message_id;
        logic [2:0]        receiver_class;
        logic [18:0]       node_address;
        logic [3:0]        sublevel;
        logic              repeat_flag;
        logic [7:0]        type_code;
        logic [7:0]        type_version;
        logic [7:0]        subcommand;
        logic [PLEN_W-1:0] payload_length;
        logic [7:0]        data_byte;
    } item_t;

    typedef struct packed
    {
        logic [ID_W-1:0]              id;
        logic [LEN_W-1:0]             len;
        logic [FRAME_BYTES-1:0][7:0]  data;
        logic                         last;
    } frame_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } queue_status_t;

endpackage
`default_nettype wire

FILE: src/cds_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cds_front
// Takes start and payload items, assembles frames and pushes finished ones.
// ----------------------------------------------------------------------------
module cds_front
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire cds_pkg::item_t          in_item,
    input  wire cds_pkg::queue_status_t  q_status,
    output logic                         push,
    output cds_pkg::frame_t              push_frame
);

    logic                                   active_reg, active_next;
    logic [cds_pkg::ID_W-1:0]               id_reg, id_next;
    logic [7:0]                             part_reg, part_next;
    logic [cds_pkg::PLEN_W-1:0]             remaining_reg, remaining_next;
    logic [cds_pkg::FRAME_BYTES-1:0][7:0]   buf_reg, buf_next;
    logic [cds_pkg::FILL_W-1:0]             fill_reg, fill_next;

    logic                                   accept;
    logic                                   is_start;
    logic                                   plen_zero;
    logic                                   last_byte;
    logic                                   full_frame;
    logic [cds_pkg::PLEN_W-1:0]             total;
    logic [cds_pkg::ID_W-1:0]               new_id;
    logic [cds_pkg::FRAME_BYTES-1:0][7:0]   hdr;
    logic [cds_pkg::FRAME_BYTES-1:0][7:0]   filled;
    logic [7:0]                             part_inc;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        is_start   = (in_item.command == cds_pkg::CMD_START);
        plen_zero  = (in_item.payload_length == '0);
        total      = in_item.payload_length + cds_pkg::HEADER_EXTRA;
        new_id     = {in_item.message_id, in_item.receiver_class, in_item.node_address};
        last_byte  = (remaining_reg == cds_pkg::PLEN_W'(1));
        full_frame = (fill_reg == cds_pkg::HEADER_FILL);
        part_inc   = part_reg + 8'd1;

        hdr    = '0;
        hdr[0] = cds_pkg::FIRST_PART;
        hdr[1] = cds_pkg::LEVEL_BASE | {4'b0000, in_item.sublevel};
        hdr[2] = total[7:0];
        hdr[3] = {in_item.repeat_flag, total[14:8]};
        hdr[4] = in_item.type_code;
        hdr[5] = in_item.type_version;
        hdr[6] = in_item.subcommand;

        filled           = buf_reg;
        filled[fill_reg] = in_item.data_byte;
    end

    // frame out
    always_comb
    begin
        push = accept && ((is_start && plen_zero)
                          || (!is_start && active_reg && (full_frame || last_byte)));
        if (is_start)
        begin
            push_frame.id   = new_id;
            push_frame.len  = cds_pkg::HEADER_LEN;
            push_frame.data = hdr;
            push_frame.last = 1'b1;
        end
        else
        begin
            push_frame.id   = id_reg;
            push_frame.len  = {1'b0, fill_reg} + cds_pkg::LEN_W'(1);
            push_frame.data = filled;
            push_frame.last = last_byte;
        end
    end

    // assembly state
    always_comb
    begin
        active_next    = active_reg;
        id_next        = id_reg;
        part_next      = part_reg;
        remaining_next = remaining_reg;
        buf_next       = buf_reg;
        fill_next      = fill_reg;
        if (accept)
        begin
            if (is_start)
            begin
                active_next    = !plen_zero;
                id_next        = new_id;
                part_next      = cds_pkg::FIRST_PART;
                remaining_next = in_item.payload_length;
                buf_next       = hdr;
                fill_next      = cds_pkg::HEADER_FILL;
            end
            else if (active_reg)
            begin
                remaining_next = remaining_reg - cds_pkg::PLEN_W'(1);
                if (last_byte)
                begin
                    active_next = 1'b0;
                end
                else if (full_frame)
                begin
                    part_next   = part_inc;
                    buf_next    = '0;
                    buf_next[0] = part_inc;
                    fill_next   = cds_pkg::FILL_W'(1);
                end
                else
                begin
                    buf_next  = filled;
                    fill_next = fill_reg + cds_pkg::FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg        <= id_next;
        part_reg      <= part_next;
        remaining_reg <= remaining_next;
        buf_reg       <= buf_next;
        fill_reg      <= fill_next;
    end

endmodule
`default_nettype wire

FILE: src/cds_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cds_queue
// Short frame queue between the assembly front and the output stage.
// ----------------------------------------------------------------------------
module cds_queue
#(
    parameter int DEPTH = cds_pkg::QUEUE_DEPTH
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire cds_pkg::frame_t         push_frame,
    input  wire logic                    pop,
    output cds_pkg::frame_t              head_frame,
    output cds_pkg::queue_status_t       status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cds_pkg::frame_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign head_frame   = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule
`default_nettype wire

FILE: src/cds_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cds_back
// Output register stage that hands queued frames to the downstream side.
// ----------------------------------------------------------------------------
module cds_back
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cds_pkg::queue_status_t  q_status,
    input  wire cds_pkg::frame_t         head_frame,
    output logic                         pop,
    output logic                         out_valid,
    output cds_pkg::frame_t              out_frame,
    input  wire logic                    out_ready
);

    logic               valid_reg, valid_next;
    cds_pkg::frame_t    frame_reg;

    assign pop       = !q_status.empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_frame = frame_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            frame_reg <= head_frame;
        end
    end

endmodule
`default_nettype wire

FILE: src/can_datagram_segmenter_top.sv
`default_nettype none
// Splits datagrams into extended CAN frames. One item (a start with the header or
// one payload byte) is taken per clock cycle while the queue is not full. A frame
// is pushed into a queue of QUEUE_DEPTH frames on the cycle its last byte is taken
// and is later popped into the output register; the input only stalls when the queue
// is full, so its depth sets how long the output may stall before the input does.
// ----------------------------------------------------------------------------
// can_datagram_segmenter_top
// Top level: stream ports, field packing, front, queue and output stage.
// ----------------------------------------------------------------------------
module can_datagram_segmenter_top
#(
    parameter int QUEUE_DEPTH = cds_pkg::QUEUE_DEPTH
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // message_id, receiver_class, node_address, sublevel, repeat_flag, type_code,
    // type_version, subcommand, payload_length, data_byte
    input  wire logic [cds_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // command
    input  wire logic [0:0]                         s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // frame_id, frame_length, byte0 .. byte7
    output logic [cds_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    output logic                                    m_axis_tlast
);

    cds_pkg::item_t             item;
    cds_pkg::queue_status_t     q_status;
    cds_pkg::frame_t            push_frame;
    cds_pkg::frame_t            head_frame;
    cds_pkg::frame_t            out_frame;
    logic                       push;
    logic                       pop;

    always_comb
    begin
        item.command        = cds_pkg::cmd_t'(s_axis_tuser[0]);
        item.message_id     = s_axis_tdata[6:0];
        item.receiver_class = s_axis_tdata[9:7];
        item.node_address   = s_axis_tdata[28:10];
        item.sublevel       = s_axis_tdata[32:29];
        item.repeat_flag    = s_axis_tdata[33];
        item.type_code      = s_axis_tdata[41:34];
        item.type_version   = s_axis_tdata[49:42];
        item.subcommand     = s_axis_tdata[57:50];
        item.payload_length = s_axis_tdata[72:58];
        item.data_byte      = s_axis_tdata[80:73];
    end

    cds_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (item),
        .q_status   (q_status),
        .push       (push),
        .push_frame (push_frame)
    );

    cds_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head_frame (head_frame),
        .status     (q_status)
    );

    cds_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .head_frame (head_frame),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_frame  (out_frame),
        .out_ready  (m_axis_tready)
    );

    always_comb
    begin
        m_axis_tdata         = '0;
        m_axis_tdata[28:0]   = out_frame.id;
        m_axis_tdata[32:29]  = out_frame.len;
        m_axis_tdata[40:33]  = out_frame.data[0];
        m_axis_tdata[48:41]  = out_frame.data[1];
        m_axis_tdata[56:49]  = out_frame.data[2];
        m_axis_tdata[64:57]  = out_frame.data[3];
        m_axis_tdata[72:65]  = out_frame.data[4];
        m_axis_tdata[80:73]  = out_frame.data[5];
        m_axis_tdata[88:81]  = out_frame.data[6];
        m_axis_tdata[96:89]  = out_frame.data[7];
        m_axis_tlast         = out_frame.last;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("frame pushed into full queue");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[32:29] != 4'd0) && (m_axis_tdata[32:29] <= 4'd8))
        else $error("frame length out of range");

    a_short_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata[32:29] != 4'd8)) |-> m_axis_tlast)
        else $error("short frame not marked last");
`endif

endmodule
`default_nettype wire
